### rtl/pps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, register indexes and payload types of the PMT pulse shaper.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TAP_W       = 16;
    localparam int NOISE_W     = 16;
    localparam int FRAC_BITS   = 15;
    localparam int PROD_W      = 32;
    localparam int PEAK_W      = 21;
    localparam int THRESH_W    = 21;
    localparam int SUM_W       = 22;
    localparam int REG_IDX_W   = 3;
    localparam int REG_DATA_W  = 21;

    // configuration register indexes (taps occupy 0..5)
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_EN  = 3'd7;

    // one frame of both channels
    typedef struct packed {
        logic        [SAMPLE_W-1:0] sample_upper;
        logic        [SAMPLE_W-1:0] sample_lower;
        logic signed [NOISE_W-1:0]  noise_upper;
        logic signed [NOISE_W-1:0]  noise_lower;
        logic                       last_frame;
    } pps_in_t;

    // one result per cell
    typedef struct packed {
        logic signed [SUM_W-1:0] cell_signal;
        logic                    above_threshold;
    } pps_out_t;

    // configuration write request
    typedef struct packed {
        logic [REG_IDX_W-1:0]  reg_index;
        logic [REG_DATA_W-1:0] reg_data;
    } pps_cfg_t;

    // control from the top level to each channel lane
    typedef struct packed {
        logic accept;   // frame request taken this cycle
        logic clear;    // accepted frame closes the cell
        logic advance;  // product stage moves into the peak update
        logic first;    // frame in the product stage opens a cell
    } lane_ctrl_t;

endpackage
`default_nettype wire

### rtl/pps_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_chan_if
// Valid/ready channel carrying one request of payload type T.
// ----------------------------------------------------------------------------
interface pps_chan_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface
`default_nettype wire

### rtl/pps_fir_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_fir_lane
// One channel: sample history, registered tap products, FIR sum, running peak.
// ----------------------------------------------------------------------------
module pps_fir_lane
    import pps_pkg::*;
#(
    parameter int TAPS = 6
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lane_ctrl_t               ctrl,
    input  logic        [SAMPLE_W-1:0] sample,
    input  logic signed [TAP_W-1:0]  taps [TAPS],
    output logic signed [PEAK_W-1:0] peak
);

    logic        [SAMPLE_W-1:0] window [TAPS];
    logic signed [PROD_W-1:0]   prod_next [TAPS];
    logic signed [PROD_W-1:0]   prod_reg [TAPS];
    logic signed [PEAK_W-1:0]   fir;
    logic signed [PEAK_W-1:0]   peak_reg;

    // current sample plus history form the filter window
    assign window[0] = sample;

    if (TAPS > 1) begin : g_hist
        logic [SAMPLE_W-1:0] hist_reg [TAPS-1];

        // history shifts on each accepted frame, clears at end of cell
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int k = 0; k < TAPS - 1; k++)
                    hist_reg[k] <= '0;
            end
            else if (ctrl.accept)
            begin
                for (int k = 0; k < TAPS - 1; k++)
                begin
                    if (ctrl.clear)
                        hist_reg[k] <= '0;
                    else if (k == 0)
                        hist_reg[k] <= sample;
                    else
                        hist_reg[k] <= hist_reg[k-1];
                end
            end
        end

        for (genvar k = 0; k < TAPS - 1; k++) begin : g_win
            assign window[k+1] = hist_reg[k];
        end
    end

    // one multiplier per tap, unsigned sample times signed tap
    always_comb
    begin
        logic signed [PROD_W:0] p;
        p = '0;
        for (int j = 0; j < TAPS; j++)
        begin
            p            = $signed({1'b0, window[j]}) * taps[j];
            prod_next[j] = p[PROD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            for (int j = 0; j < TAPS; j++)
                prod_reg[j] <= prod_next[j];
        end
    end

    // floor-shift each product and add them up
    always_comb
    begin
        fir = '0;
        for (int j = 0; j < TAPS; j++)
            fir = fir + PEAK_W'(prod_reg[j] >>> FRAC_BITS);
    end

    // running maximum, loaded outright on a cell's first frame
    always_comb
    begin
        if (ctrl.first || (fir > peak_reg))
            peak = fir;
        else
            peak = peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            peak_reg <= '0;
        else if (ctrl.advance)
            peak_reg <= peak;
    end

endmodule
`default_nettype wire

### rtl/pps_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_merge
// Sums both peaks; with noise enabled adds noise and thresholds; holds result.
// ----------------------------------------------------------------------------
module pps_merge
    import pps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic signed [PEAK_W-1:0]  peak_upper,
    input  logic signed [PEAK_W-1:0]  peak_lower,
    input  logic signed [NOISE_W-1:0] noise_upper,
    input  logic signed [NOISE_W-1:0] noise_lower,
    input  logic        [THRESH_W-1:0] threshold,
    input  logic                      noise_enable,
    output logic                      ready,
    pps_chan_if.source                result
);

    logic                      s2v_reg;
    logic                      s2v_next;
    logic signed [PEAK_W-1:0]  pu_reg;
    logic signed [PEAK_W-1:0]  pl_reg;
    logic signed [NOISE_W-1:0] nu_reg;
    logic signed [NOISE_W-1:0] nl_reg;
    logic                      ov_reg;
    logic                      ov_next;
    pps_out_t                  out_reg;
    pps_out_t                  out_next;
    logic                      o_free;
    logic                      s2_fire;
    logic signed [SUM_W-1:0]   noise_sum;
    logic signed [SUM_W-1:0]   sum;
    logic                      above;

    assign o_free  = !ov_reg || result.ready;
    assign ready   = !s2v_reg || o_free;
    assign s2_fire = s2v_reg && o_free;

    // final peaks of the cell wait here
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pu_reg <= peak_upper;
            pl_reg <= peak_lower;
            nu_reg <= noise_upper;
            nl_reg <= noise_lower;
        end
    end

    // sum and threshold
    always_comb
    begin
        noise_sum = noise_enable ? (SUM_W'(nu_reg) + SUM_W'(nl_reg)) : '0;
        sum       = SUM_W'(pu_reg) + SUM_W'(pl_reg) + noise_sum;
        above     = !noise_enable || (sum > $signed({1'b0, threshold}));
        out_next.cell_signal     = above ? sum : '0;
        out_next.above_threshold = above;
    end

    // stage and output valid flags
    always_comb
    begin
        s2v_next = s2v_reg;
        if (load)
            s2v_next = 1'b1;
        else if (s2_fire)
            s2v_next = 1'b0;

        ov_next = ov_reg;
        if (s2_fire)
            ov_next = 1'b1;
        else if (result.ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2v_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            s2v_reg <= s2v_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
            out_reg <= out_next;
    end

    assign result.valid = ov_reg;
    assign result.data  = out_reg;

endmodule
`default_nettype wire

### rtl/pmt_pulse_shaper_peak_threshold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmt_pulse_shaper_peak_threshold
// Two-channel FIR pulse shaper with per-cell peak hold and noise threshold.
// ----------------------------------------------------------------------------
// Accepts one frame request per clock unless stalled. Each frame feeds two
// parallel FIR lanes (upper and lower channel) whose tap products are
// registered, then summed and folded into a running peak; a frame flagged
// last_frame closes the cell and the merge stage adds the two peaks and,
// with noise enabled, adds the noise and applies the threshold. The result
// is registered at the merge output. Input stalls only while the output
// holds a refused result, the merge stage holds the next one, and a third
// cell's last frame waits in the product stage.
module pmt_pulse_shaper_peak_threshold
    import pps_pkg::*;
#(
    parameter int TAPS = 6
)
(
    input  logic       clk,
    input  logic       rst_n,
    pps_chan_if.sink   frame,
    pps_chan_if.sink   cfg,
    pps_chan_if.source result
);

    logic signed [TAP_W-1:0]    tap_reg [TAPS];
    logic        [THRESH_W-1:0] thresh_reg;
    logic                       noise_en_reg;
    logic                       s1v_reg;
    logic                       s1_last_reg;
    logic                       first_reg;
    logic signed [NOISE_W-1:0]  s1_nu_reg;
    logic signed [NOISE_W-1:0]  s1_nl_reg;
    logic                       s2_ready;
    logic                       s1_fire;
    logic                       accept;
    lane_ctrl_t                 lane_ctrl;
    logic signed [PEAK_W-1:0]   peak_upper;
    logic signed [PEAK_W-1:0]   peak_lower;
    pps_in_t                    frm;
    pps_cfg_t                   cfg_req;

    assign frm     = frame.data;
    assign cfg_req = cfg.data;

    // configuration registers, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TAPS; j++)
                tap_reg[j] <= '0;
            thresh_reg   <= '0;
            noise_en_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg_req.reg_index)
                REG_THRESHOLD: thresh_reg   <= cfg_req.reg_data[THRESH_W-1:0];
                REG_NOISE_EN:  noise_en_reg <= cfg_req.reg_data[0];
                default:
                begin
                    for (int j = 0; j < TAPS; j++)
                    begin
                        if (cfg_req.reg_index == REG_IDX_W'(j))
                            tap_reg[j] <= cfg_req.reg_data[TAP_W-1:0];
                    end
                end
            endcase
        end
    end

    // product stage handshake; only a last frame ever waits on the merge
    assign s1_fire     = s1v_reg && (!s1_last_reg || s2_ready);
    assign frame.ready = !s1v_reg || s1_fire;
    assign accept      = frame.valid && frame.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1v_reg     <= 1'b0;
            s1_last_reg <= 1'b0;
            first_reg   <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                s1v_reg     <= 1'b1;
                s1_last_reg <= frm.last_frame;
            end
            else if (s1_fire)
            begin
                s1v_reg <= 1'b0;
            end
            if (s1_fire)
                first_reg <= s1_last_reg;
        end
    end

    // noise rides along with the frame
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_nu_reg <= frm.noise_upper;
            s1_nl_reg <= frm.noise_lower;
        end
    end

    assign lane_ctrl.accept  = accept;
    assign lane_ctrl.clear   = frm.last_frame;
    assign lane_ctrl.advance = s1_fire;
    assign lane_ctrl.first   = first_reg;

    // channel lanes
    pps_fir_lane #(.TAPS(TAPS)) u_lane_upper (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .sample (frm.sample_upper),
        .taps   (tap_reg),
        .peak   (peak_upper)
    );

    pps_fir_lane #(.TAPS(TAPS)) u_lane_lower (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .sample (frm.sample_lower),
        .taps   (tap_reg),
        .peak   (peak_lower)
    );

    // merge of both peaks into the cell result
    pps_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s1_fire && s1_last_reg),
        .peak_upper   (peak_upper),
        .peak_lower   (peak_lower),
        .noise_upper  (s1_nu_reg),
        .noise_lower  (s1_nl_reg),
        .threshold    (thresh_reg),
        .noise_enable (noise_en_reg),
        .ready        (s2_ready),
        .result       (result)
    );

    // assertions
    a_cell_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> first_reg)
        else $error("peak not reloaded after a closed cell");

    a_only_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (s1v_reg && !s1_fire) |-> (s1_last_reg && !s2_ready))
        else $error("non-last frame held in product stage");

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        !frame.ready |-> (s1v_reg && result.valid && !result.ready))
        else $error("frame request refused without downstream backpressure");

endmodule
`default_nettype wire
